// File: rtl/core/bitmap_page_frame_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame allocator
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared constants, codes and control types of the page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

  localparam int unsigned PAGE_COUNT  = 65536;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned MAP_WORDS   = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int unsigned WORD_IDX_W  = $clog2(MAP_WORDS);
  localparam int unsigned MAP_DATA_W  = 2 * WORD_BITS;

  localparam int unsigned GRP_W       = 8;
  localparam int unsigned GRPS        = WORD_BITS / GRP_W;
  localparam int unsigned GRP_IDX_W   = $clog2(GRPS);
  localparam int unsigned GRP_BIT_W   = $clog2(GRP_W);

  localparam int unsigned ACT_W       = 2;
  localparam int unsigned PAGE_W      = 20;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned PAGE_CMP_W  = PAGE_W + 1;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC         = 2'd0,
    ACT_FREE          = 2'd1,
    ACT_MARK_USABLE   = 2'd2,
    ACT_MARK_UNUSABLE = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE         = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW_READ,
    S_RMW_WRITE,
    S_SCAN,
    S_FIND_GRP,
    S_FIND_BIT,
    S_ALLOC_WRITE,
    S_RESPOND
  } state_e;

  typedef struct packed {
    logic    load;
    logic    addr_inc;
    logic    rd_en;
    logic    clr_wr;
    logic    rmw_wr;
    logic    alloc_wr;
    logic    find_grp;
    logic    find_bit;
    logic    res_load;
    status_e res_status;
    logic    res_found;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_alloc;
    logic in_page_oor;
    logic rd_vld;
    logic cand_nz;
    logic rd_last;
    logic addr_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/bpfa_datapath.sv
// ----------------------------------------------------------------------------
// bpfa_datapath
// Bitmap memory (usable and used bits per word), read-modify-write,
// first-fit candidate search and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_datapath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  bpfa_pkg::ctrl_cmd_t           cmd_i,
  output bpfa_pkg::dp_status_t          status_o,
  input  wire [bpfa_pkg::ACT_W-1:0]     in_action_i,
  input  wire [bpfa_pkg::PAGE_W-1:0]    in_page_i,
  input  wire                           out_ready_i,
  output logic                          out_valid_o,
  output logic [bpfa_pkg::PAGE_W-1:0]   out_page_o,
  output logic [bpfa_pkg::STAT_W-1:0]   out_status_o
);

  logic [bpfa_pkg::MAP_DATA_W-1:0] map_mem [bpfa_pkg::MAP_WORDS];

  bpfa_pkg::action_e                act_q;
  logic [bpfa_pkg::PAGE_W-1:0]      page_q;
  logic [bpfa_pkg::WORD_IDX_W-1:0]  addr_q, addr_d;
  logic [bpfa_pkg::MAP_DATA_W-1:0]  rd_data_q;
  logic [bpfa_pkg::WORD_IDX_W-1:0]  rd_addr_q;
  logic                             rd_vld_q;
  logic [bpfa_pkg::GRP_IDX_W-1:0]   grp_q, grp_d;
  logic [bpfa_pkg::GRP_W-1:0]       grp_bits_q;
  logic [bpfa_pkg::GRP_BIT_W-1:0]   bit_q, bit_d;
  logic                             out_vld_q;
  logic [bpfa_pkg::PAGE_W-1:0]      res_page_q;
  logic [bpfa_pkg::STAT_W-1:0]      res_status_q;

  logic [bpfa_pkg::WORD_BITS-1:0]   usable_w, used_w, cand, bit_mask, alloc_mask;
  logic [bpfa_pkg::WORD_BITS-1:0]   rmw_usable, rmw_used;
  logic [bpfa_pkg::MAP_DATA_W-1:0]  wr_data;
  logic [bpfa_pkg::WORD_IDX_W-1:0]  wr_addr;
  logic                             wr_en;
  logic [bpfa_pkg::PAGE_W-1:0]      found_page;
  logic [bpfa_pkg::WORD_IDX_W-1:0]  in_word;

  assign in_word = in_page_i[bpfa_pkg::BIT_IDX_W +: bpfa_pkg::WORD_IDX_W];

  always_comb begin
    if (addr_q == bpfa_pkg::LAST_WORD) begin
      addr_d = '0;
    end else begin
      addr_d = addr_q + 1'b1;
    end
  end

  // candidate word, page zero is never handed out
  always_comb begin
    usable_w = rd_data_q[bpfa_pkg::WORD_BITS-1:0];
    used_w   = rd_data_q[bpfa_pkg::MAP_DATA_W-1:bpfa_pkg::WORD_BITS];
    cand     = usable_w & ~used_w;
    if (rd_addr_q == '0) begin
      cand[0] = 1'b0;
    end
  end

  always_comb begin
    bit_mask   = bpfa_pkg::WORD_BITS'(1) << page_q[bpfa_pkg::BIT_IDX_W-1:0];
    alloc_mask = bpfa_pkg::WORD_BITS'(1) << {grp_q, bit_q};
    rmw_usable = usable_w;
    rmw_used   = used_w;
    case (act_q)
      bpfa_pkg::ACT_FREE:          rmw_used   = used_w & ~bit_mask;
      bpfa_pkg::ACT_MARK_USABLE:   rmw_usable = usable_w | bit_mask;
      bpfa_pkg::ACT_MARK_UNUSABLE: rmw_usable = usable_w & ~bit_mask;
      default:                     rmw_used   = used_w;
    endcase
  end

  always_comb begin
    wr_en   = cmd_i.clr_wr | cmd_i.rmw_wr | cmd_i.alloc_wr;
    wr_addr = cmd_i.clr_wr ? addr_q : rd_addr_q;
    if (cmd_i.clr_wr) begin
      wr_data = '0;
    end else if (cmd_i.alloc_wr) begin
      wr_data = {used_w | alloc_mask, usable_w};
    end else begin
      wr_data = {rmw_used, rmw_usable};
    end
  end

  // lowest nonzero byte group, then lowest bit inside it
  always_comb begin
    grp_d = '0;
    for (int g = bpfa_pkg::GRPS - 1; g >= 0; g--) begin
      if (cand[g*bpfa_pkg::GRP_W +: bpfa_pkg::GRP_W] != '0) begin
        grp_d = bpfa_pkg::GRP_IDX_W'(g);
      end
    end
  end

  always_comb begin
    bit_d = '0;
    for (int b = bpfa_pkg::GRP_W - 1; b >= 0; b--) begin
      if (grp_bits_q[b]) begin
        bit_d = bpfa_pkg::GRP_BIT_W'(b);
      end
    end
  end

  assign found_page = bpfa_pkg::PAGE_W'({rd_addr_q, grp_q, bit_q});

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= map_mem[addr_q];
      rd_addr_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        addr_q <= (bpfa_pkg::action_e'(in_action_i) == bpfa_pkg::ACT_ALLOC) ? '0 : in_word;
      end else if (cmd_i.addr_inc) begin
        addr_q <= addr_d;
      end
      if (cmd_i.res_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= bpfa_pkg::action_e'(in_action_i);
      page_q <= in_page_i;
    end
    if (cmd_i.find_grp) begin
      grp_q      <= grp_d;
      grp_bits_q <= cand[grp_d*bpfa_pkg::GRP_W +: bpfa_pkg::GRP_W];
    end
    if (cmd_i.find_bit) begin
      bit_q <= bit_d;
    end
    if (cmd_i.res_load) begin
      res_page_q   <= cmd_i.res_found ? found_page : '0;
      res_status_q <= cmd_i.res_status;
    end
  end

  always_comb begin
    status_o.in_is_alloc = (bpfa_pkg::action_e'(in_action_i) == bpfa_pkg::ACT_ALLOC);
    status_o.in_page_oor = ({1'b0, in_page_i} >=
                            bpfa_pkg::PAGE_CMP_W'(bpfa_pkg::PAGE_COUNT));
    status_o.rd_vld      = rd_vld_q;
    status_o.cand_nz     = (cand != '0);
    status_o.rd_last     = (rd_addr_q == bpfa_pkg::LAST_WORD);
    status_o.addr_last   = (addr_q == bpfa_pkg::LAST_WORD);
    status_o.out_free    = !out_vld_q || out_ready_i;
  end

  assign out_valid_o  = out_vld_q;
  assign out_page_o   = res_page_q;
  assign out_status_o = res_status_q;

endmodule

`default_nettype wire

// File: rtl/core/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer: clearing pass, read-modify-write, first-fit scan and response.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  bpfa_pkg::dp_status_t  status_i,
  output bpfa_pkg::ctrl_cmd_t   cmd_o
);

  bpfa_pkg::state_e  state_q, state_d;
  bpfa_pkg::status_e pend_status_q, pend_status_d;
  logic              pend_found_q, pend_found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= bpfa_pkg::S_CLEAR;
      pend_status_q <= bpfa_pkg::ST_DONE;
      pend_found_q  <= 1'b0;
    end else begin
      state_q       <= state_d;
      pend_status_q <= pend_status_d;
      pend_found_q  <= pend_found_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    pend_status_d = pend_status_q;
    pend_found_d  = pend_found_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      bpfa_pkg::S_CLEAR: begin
        cmd_o.clr_wr   = 1'b1;
        cmd_o.addr_inc = 1'b1;
        if (status_i.addr_last) begin
          state_d = bpfa_pkg::S_IDLE;
        end
      end
      bpfa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load   = 1'b1;
          pend_found_d = 1'b0;
          if (status_i.in_is_alloc) begin
            state_d = bpfa_pkg::S_SCAN;
          end else if (status_i.in_page_oor) begin
            pend_status_d = bpfa_pkg::ST_OUT_OF_RANGE;
            state_d       = bpfa_pkg::S_RESPOND;
          end else begin
            state_d = bpfa_pkg::S_RMW_READ;
          end
        end
      end
      bpfa_pkg::S_RMW_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = bpfa_pkg::S_RMW_WRITE;
      end
      bpfa_pkg::S_RMW_WRITE: begin
        cmd_o.rmw_wr  = 1'b1;
        pend_status_d = bpfa_pkg::ST_DONE;
        state_d       = bpfa_pkg::S_RESPOND;
      end
      bpfa_pkg::S_SCAN: begin
        if (status_i.rd_vld && status_i.cand_nz) begin
          state_d = bpfa_pkg::S_FIND_GRP;
        end else if (status_i.rd_vld && status_i.rd_last) begin
          pend_status_d = bpfa_pkg::ST_NO_FREE;
          state_d       = bpfa_pkg::S_RESPOND;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_inc = 1'b1;
        end
      end
      bpfa_pkg::S_FIND_GRP: begin
        cmd_o.find_grp = 1'b1;
        state_d        = bpfa_pkg::S_FIND_BIT;
      end
      bpfa_pkg::S_FIND_BIT: begin
        cmd_o.find_bit = 1'b1;
        state_d        = bpfa_pkg::S_ALLOC_WRITE;
      end
      bpfa_pkg::S_ALLOC_WRITE: begin
        cmd_o.alloc_wr = 1'b1;
        pend_status_d  = bpfa_pkg::ST_DONE;
        pend_found_d   = 1'b1;
        state_d        = bpfa_pkg::S_RESPOND;
      end
      bpfa_pkg::S_RESPOND: begin
        if (status_i.out_free) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = pend_status_q;
          cmd_o.res_found  = pend_found_q;
          state_d          = bpfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpfa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit physical page frame allocator over usable/used bitmaps.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tdata: action, page_number); one response per
// request leaves on m_axis (tdata: result_page, status).
// After reset the bitmap memory is swept to zero, one word per cycle, over all
// MAP_WORDS (1024) words; s_axis_tready_o stays low during that pass.
// One request is in work at a time:
//   out of range: response straight from accept; free / mark: read, write.
//   allocate: one bitmap word read per cycle from word 0; a hit is then
//   found by group and bit search and written; a miss ends at the last word.
// The scan rate is set by the single read port of the bitmap memory.
// The response sits in an output register; the next request is accepted
// while it waits. If m_axis_tready_i stays low, the following response
// holds inside the block and no further request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_page_frame_allocator_assert.svh"

module bitmap_page_frame_allocator (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [1:0] action, [21:2] page_number, [23:22] zero
  input  wire [bpfa_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // [19:0] result_page, [21:20] status, [23:22] zero
  output logic [bpfa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  bpfa_pkg::ctrl_cmd_t          cmd;
  bpfa_pkg::dp_status_t         dp_status;
  logic [bpfa_pkg::PAGE_W-1:0]  out_page;
  logic [bpfa_pkg::STAT_W-1:0]  out_status;

  bpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  bpfa_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .in_action_i  (s_axis_tdata_i[bpfa_pkg::ACT_W-1:0]),
    .in_page_i    (s_axis_tdata_i[bpfa_pkg::ACT_W +: bpfa_pkg::PAGE_W]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_page_o   (out_page),
    .out_status_o (out_status)
  );

  assign m_axis_tdata_o = bpfa_pkg::OUT_TDATA_W'({out_status, out_page});

  `BPFA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "request accepted while another in work")
  `BPFA_ASSERT_IMPL(a_nofree_zero, m_axis_tvalid_o && out_status == bpfa_pkg::ST_NO_FREE, out_page == '0, "no-free response carries a page")
  `BPFA_ASSERT_IMPL(a_page_done, m_axis_tvalid_o && out_page != '0, out_status == bpfa_pkg::ST_DONE, "page returned with error status")

endmodule

`default_nettype wire
